// ===== design/hids_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hids_pkg;

   // Table geometry and field widths.
   localparam int SLOTS  = 1024;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int KEY_W  = 64;
   localparam int TAG_W  = 8;
   localparam int CFG_W  = 10;

   // Fibonacci hashing multiplier (2^64 divided by the golden ratio).
   localparam logic [KEY_W-1:0] HASH_MULT = 64'd11400714819323198485;

   // Request opcodes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_ZERO      = 3'd2,
      ST_FULL      = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef struct packed {
      logic             opcode;
      logic [KEY_W-1:0] ident;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_index;
   } rsp_type;

   // One slot of the table: the entry is live only while its tag equals the current epoch.
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      entry_type         entry;
   } slot_wr_type;

   // Mask of the span in use: smallest power of two at least twice the limit (two for a zero limit), capped at SLOTS.
   function automatic logic [SLOT_W-1:0] span_mask(input logic [CFG_W-1:0] limit);
      logic [CFG_W:0] v;
      if (limit == '0) begin
         v = (CFG_W+1)'(1);
      end else begin
         v = {limit, 1'b0} - (CFG_W+1)'(1);
      end
      for (int s = 1; s <= CFG_W; s = s * 2) begin
         v = v | (v >> s);
      end
      if (v > (CFG_W+1)'(SLOTS - 1)) begin
         return SLOT_W'(SLOTS - 1);
      end
      return v[SLOT_W-1:0];
   endfunction

   // Home slot: only the low bits of the 64-bit product are needed.
   function automatic logic [SLOT_W-1:0] hash_slot(input logic [KEY_W-1:0] ident);
      logic [2*SLOT_W-1:0] prod;
      prod = ident[SLOT_W-1:0] * HASH_MULT[SLOT_W-1:0];
      return prod[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/hids_slot_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hids_slot_store import hids_pkg::*; (
   input  wire logic              clock,
   input  wire slot_wr_type       wr,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output entry_type              rd_entry
);

   entry_type mem [SLOTS];
   entry_type rd_entry_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

// ===== design/hashed_id_set_duplicate_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port group  Direction  Handshake            Transfer carries
// req_        in         req_valid/req_stall  req_type: opcode, ident
// rsp_        out        rsp_valid/rsp_stall  rsp_type: status, slot_index
// csr_        in         csr_valid/csr_ready  max_entries
//
// An insert probes one slot per cycle through the slot memory read port, at most the span,
// then waits in S_DONE until the output register is free; req_stall stays high until the
// result is stored there. A zero identifier and a clear go straight to S_DONE; every 255th
// clear first sweeps every slot of the memory.
// After reset a clearing pass over the slot memory runs while req_stall stays high. One item
// is in work at a time; a result waiting on rsp_stall delays the next one, which then stalls requests.

module hashed_id_set_duplicate_check import hids_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_data
);

   typedef enum logic [1:0] {
      S_SWEEP,
      S_IDLE,
      S_PROBE,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [SLOT_W-1:0] tries_ff, tries_in;
   logic [SLOT_W-1:0] sweep_ff, sweep_in;
   logic [SLOT_W-1:0] mask_ff, mask_in;
   logic [TAG_W-1:0]  epoch_ff, epoch_in;
   logic [KEY_W-1:0]  ident_ff, ident_in;
   logic              clr_reply_ff, clr_reply_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   slot_wr_type       wr;
   logic [SLOT_W-1:0] rd_addr;
   entry_type         rd_entry;

   logic              accept;
   logic              rsp_free;
   logic              slot_live;
   logic              key_match;
   logic              last_try;
   logic [SLOT_W-1:0] home_pos;
   logic [SLOT_W-1:0] next_pos;

   hids_slot_store u_store (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   // Handshake status.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Probe evaluation on the slot read back from the memory.
   assign home_pos  = hash_slot(req_data.ident) & mask_ff;
   assign next_pos  = (pos_ff + SLOT_W'(1)) & mask_ff;
   assign slot_live = (rd_entry.tag == epoch_ff);
   assign key_match = (rd_entry.key == ident_ff);
   assign last_try  = (tries_ff == mask_ff);

   // Next-state logic: sequencer, memory access and result staging.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      tries_in     = tries_ff;
      sweep_in     = sweep_ff;
      mask_in      = mask_ff;
      epoch_in     = epoch_ff;
      ident_in     = ident_ff;
      clr_reply_in = clr_reply_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;
      rd_addr      = pos_ff;

      if (csr_valid && csr_ready) begin
         mask_in = span_mask(csr_data);
      end

      // The output register empties on a transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_SWEEP: begin
            wr.en    = 1'b1;
            wr.addr  = sweep_ff;
            wr.entry = '0;
            sweep_in = sweep_ff + SLOT_W'(1);
            if (sweep_ff == SLOT_W'(SLOTS - 1)) begin
               epoch_in     = TAG_W'(1);
               clr_reply_in = 1'b0;
               state_in     = clr_reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = home_pos;
            if (accept) begin
               ident_in          = req_data.ident;
               pos_in            = home_pos;
               tries_in          = '0;
               res_in.slot_index = '0;
               if (req_data.opcode == OP_CLEAR) begin
                  res_in.status = ST_CLEARED;
                  if (epoch_ff == '1) begin
                     sweep_in     = '0;
                     clr_reply_in = 1'b1;
                     state_in     = S_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + TAG_W'(1);
                     state_in = S_DONE;
                  end
               end else if (req_data.ident == '0) begin
                  res_in.status = ST_ZERO;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (!slot_live) begin
               wr.en             = 1'b1;
               wr.addr           = pos_ff;
               wr.entry.tag      = epoch_ff;
               wr.entry.key      = ident_ff;
               res_in.status     = ST_INSERTED;
               res_in.slot_index = pos_ff;
               state_in          = S_DONE;
            end else if (key_match) begin
               res_in.status     = ST_DUPLICATE;
               res_in.slot_index = pos_ff;
               state_in          = S_DONE;
            end else if (last_try) begin
               res_in.status     = ST_FULL;
               res_in.slot_index = '0;
               state_in          = S_DONE;
            end else begin
               pos_in   = next_pos;
               tries_in = tries_ff + SLOT_W'(1);
               rd_addr  = next_pos;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         mask_ff      <= span_mask(CFG_W'(512));
         epoch_ff     <= TAG_W'(1);
         clr_reply_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         mask_ff      <= mask_in;
         epoch_ff     <= epoch_in;
         clr_reply_ff <= clr_reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      tries_ff    <= tries_in;
      ident_ff    <= ident_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/hids_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hids_checker import hids_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire rsp_type          rsp_data
);

   // A stalled result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Results that name no slot carry slot index zero.
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_ZERO || rsp_data.status == ST_FULL
                    || rsp_data.status == ST_CLEARED) |-> rsp_data.slot_index == '0)
      else $error("slot index set on a result without a slot");

   // Reset starts the clearing pass with no result pending.
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not held off after reset");

   // One request in work at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another was in work");

endmodule

bind hashed_id_set_duplicate_check hids_checker u_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import hids_pkg::*;

   // Quiet cycles needed before a limit write: covers a clearing sweep of the slot memory.
   localparam int SETTLE_CYCLES = 1100;
   localparam int TAIL_CYCLES   = 1100;
   localparam int PHASE_ITEMS   = 110;

   typedef enum logic [1:0] {
      DO_REQUEST,
      DO_LIMIT,
      DO_DRAIN
   } backlog_kind_type;

   typedef struct packed {
      backlog_kind_type kind;
      req_type          req;
      logic [CFG_W-1:0] limit;
   } backlog_entry_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   req_type          req_data  = '0;
   logic             req_stall;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data  = '0;

   // Operations waiting to be sent, and the outcomes the set should report, oldest first.
   backlog_entry_type op_backlog[$];
   rsp_type      awaited_outcomes[$];
   logic [KEY_W-1:0] recent_ids[$];

   // Own copy of the set held by the block.
   logic [KEY_W-1:0] set_keys [SLOTS];
   bit               set_held [SLOTS];
   logic [CFG_W-1:0] set_limit = 10'd512;

   int  fault_count  = 0;
   int  quiet_cycles = 0;
   int  gap_left     = 0;
   int  req_calm     = 0;
   int  hold_left    = 0;
   int  rsp_calm     = 0;
   int  issued       = 0;
   logic req_xfer    = 1'b0;
   logic csr_xfer    = 1'b0;

   hashed_id_set_duplicate_check dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Probe span: smallest power of two at least twice the limit (two for a zero limit), capped at the slot store.
   function automatic int span_of(input logic [CFG_W-1:0] limit);
      int need;
      int span;
      need = (limit == '0) ? 2 : 2 * int'(limit);
      span = 1;
      while (span < need && span * 2 <= SLOTS) begin
         span = span * 2;
      end
      return span;
   endfunction

   // Applies one operation to the local set and returns the outcome the block must report.
   function automatic rsp_type apply_to_set(input req_type r);
      rsp_type          o;
      logic [KEY_W-1:0] product;
      int               span;
      int               pos;
      o.status     = ST_FULL;
      o.slot_index = '0;
      if (r.opcode == OP_CLEAR) begin
         for (int i = 0; i < SLOTS; i++) begin
            set_held[i] = 1'b0;
         end
         o.status = ST_CLEARED;
         return o;
      end
      if (r.ident == '0) begin
         o.status = ST_ZERO;
         return o;
      end
      span    = span_of(set_limit);
      product = r.ident * HASH_MULT;
      pos     = int'(product[SLOT_W-1:0]) & (span - 1);
      for (int tries = 0; tries < span; tries++) begin
         if (!set_held[pos]) begin
            set_keys[pos] = r.ident;
            set_held[pos] = 1'b1;
            o.status      = ST_INSERTED;
            o.slot_index  = pos[SLOT_W-1:0];
            return o;
         end
         if (set_keys[pos] == r.ident) begin
            o.status     = ST_DUPLICATE;
            o.slot_index = pos[SLOT_W-1:0];
            return o;
         end
         pos = (pos + 1) & (span - 1);
      end
      return o;
   endfunction

   // Idle length: mostly none or short, now and then long; none at all during a calm stretch.
   function automatic int idle_span(input int calm);
      int r;
      if (calm != 0) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 150);
   endfunction

   // Identifier mix: zero, repeats, ids sharing a home slot with earlier ones, and fresh ids.
   function automatic logic [KEY_W-1:0] pick_ident();
      logic [KEY_W-1:0] id;
      int               r;
      r  = $urandom_range(0, 99);
      id = {$urandom(), $urandom()};
      if (r < 5) begin
         id = '0;
      end else if (r < 40 && recent_ids.size() != 0) begin
         id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      end else if (r < 55 && recent_ids.size() != 0) begin
         id[SLOT_W-1:0] = recent_ids[$urandom_range(0, recent_ids.size() - 1)][SLOT_W-1:0];
      end
      if (id != '0) begin
         recent_ids.push_back(id);
         if (recent_ids.size() > 32) begin
            void'(recent_ids.pop_front());
         end
      end
      return id;
   endfunction

   task automatic queue_request(input logic op, input logic [KEY_W-1:0] id);
      backlog_entry_type e;
      e.kind       = DO_REQUEST;
      e.req.opcode = op;
      e.req.ident  = id;
      e.limit      = '0;
      op_backlog.push_back(e);
      issued++;
   endtask

   task automatic queue_limit(input logic [CFG_W-1:0] value);
      backlog_entry_type e;
      e.kind  = DO_LIMIT;
      e.req   = '0;
      e.limit = value;
      op_backlog.push_back(e);
   endtask

   task automatic queue_drain();
      backlog_entry_type e;
      e.kind  = DO_DRAIN;
      e.req   = '0;
      e.limit = '0;
      op_backlog.push_back(e);
   endtask

   // A clear (unless skipped) followed by inserts, with the odd stray clear in between.
   task automatic queue_sequence(input int len, input bit with_clear);
      if (with_clear) begin
         queue_request(OP_CLEAR, {$urandom(), $urandom()});
      end
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 4) begin
            queue_request(OP_CLEAR, {$urandom(), $urandom()});
         end else begin
            queue_request(OP_INSERT, pick_ident());
         end
      end
   endtask

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Sender: presents the backlog one transfer at a time, with gaps, drains and limit writes.
   always @(negedge clock) begin
      logic             next_valid;
      logic             next_csr;
      req_type          next_req;
      logic [CFG_W-1:0] next_limit;
      backlog_entry_type head;
      next_valid = req_valid;
      next_csr   = csr_valid;
      next_req   = req_data;
      next_limit = csr_data;
      if (!reset) begin
         if (req_xfer) begin
            next_valid = 1'b0;
         end
         if (csr_xfer) begin
            next_csr = 1'b0;
         end
         if (!next_valid && !next_csr && op_backlog.size() != 0) begin
            head = op_backlog[0];
            if (gap_left != 0) begin
               gap_left--;
            end else if (head.kind == DO_REQUEST) begin
               next_valid = 1'b1;
               next_req   = head.req;
               void'(op_backlog.pop_front());
               gap_left = idle_span(req_calm);
               if (req_calm != 0) begin
                  req_calm--;
               end else if ($urandom_range(0, 49) == 0) begin
                  req_calm = $urandom_range(20, 100);
               end
            end else if (head.kind == DO_DRAIN) begin
               if (awaited_outcomes.size() == 0) begin
                  void'(op_backlog.pop_front());
               end
            end else if (quiet_cycles >= SETTLE_CYCLES) begin
               next_csr   = 1'b1;
               next_limit = head.limit;
               void'(op_backlog.pop_front());
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_req;
      csr_valid <= next_csr;
      csr_data  <= next_limit;
   end

   // Receiver: stall runs of random length, with rsp_stall always dropped between two runs.
   always @(negedge clock) begin
      if (reset || hold_left == 0) begin
         rsp_stall <= 1'b0;
         hold_left = idle_span(rsp_calm);
         if (rsp_calm != 0) begin
            rsp_calm--;
         end else if ($urandom_range(0, 49) == 0) begin
            rsp_calm = $urandom_range(20, 100);
         end
      end else begin
         rsp_stall <= 1'b1;
         hold_left--;
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted result.
   always @(posedge clock) begin
      rsp_type want;
      req_xfer <= !reset && req_valid && !req_stall;
      csr_xfer <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            set_limit = csr_data;
         end
         if (req_valid && !req_stall) begin
            awaited_outcomes.push_back(apply_to_set(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               note_fault($sformatf("unexpected result: status %0d slot %0d",
                                    rsp_data.status, rsp_data.slot_index));
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.slot_index !== want.slot_index) begin
                  note_fault($sformatf("mismatch: expected status %0d slot %0d, got %0d slot %0d",
                                       want.status, want.slot_index,
                                       rsp_data.status, rsp_data.slot_index));
               end
            end
         end
         if (awaited_outcomes.size() == 0 && !req_valid && !csr_valid) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [CFG_W-1:0] limits [10];
      int               span;
      int               start;
      limits = '{10'd1, 10'd0, 10'd3, 10'd1023, 10'd6, 10'd100, 10'd2, 10'd512, 10'd700,
                 10'd37};

      // Directed part at the reset limit: zero id, repeats, a shared home slot, clear.
      queue_request(OP_INSERT, 64'd0);
      queue_request(OP_INSERT, 64'd1);
      queue_request(OP_INSERT, 64'd1);
      queue_request(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(OP_INSERT, 64'h8000_0000_0000_0001);
      queue_request(OP_INSERT, 64'h8000_0000_0000_0001);
      queue_request(OP_INSERT, 64'h5555_5555_5555_5555);
      queue_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_drain();
      queue_request(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_request(OP_INSERT, 64'd1);
      // Shrink the span while entries are still held, then fill the two slots.
      queue_limit(10'd1);
      queue_request(OP_INSERT, 64'd1);
      queue_request(OP_INSERT, 64'h8000_0000_0000_0001);
      queue_request(OP_INSERT, 64'd2);
      queue_request(OP_INSERT, 64'd3);
      queue_request(OP_CLEAR, 64'd0);
      queue_request(OP_INSERT, 64'd2);
      queue_request(OP_INSERT, 64'd3);
      queue_request(OP_INSERT, 64'd4);
      queue_request(OP_INSERT, 64'd3);
      queue_request(OP_INSERT, 64'd0);
      queue_limit(10'd1023);
      queue_request(OP_INSERT, 64'd4);
      queue_request(OP_INSERT, 64'd2);

      // Random phases, one per limit setting.
      foreach (limits[p]) begin
         queue_limit(limits[p]);
         span  = span_of(limits[p]);
         start = issued;
         if (p == 5) begin
            // A long run of inserts at one setting so the probe walks long chains.
            queue_sequence(span + 40, 1'b1);
         end
         if (p == 7) begin
            // Many clears, each followed by an insert, to drive the block's clear bookkeeping toward its wrap.
            for (int i = 0; i < 200; i++) begin
               queue_request(OP_CLEAR, {$urandom(), $urandom()});
               queue_request(OP_INSERT, pick_ident());
            end
         end
         // The first sequence sometimes keeps entries from the previous setting.
         queue_sequence($urandom_range(1, 8), $urandom_range(0, 1));
         while (issued - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
               queue_sequence($urandom_range(1, (2 * span + 3 < 48) ? 2 * span + 3 : 48), 1'b1);
            end else begin
               queue_sequence($urandom_range(1, (2 * span + 3 < 10) ? 2 * span + 3 : 10), 1'b1);
            end
            if ($urandom_range(0, 9) == 0) begin
               queue_drain();
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (op_backlog.size() != 0 || req_valid || csr_valid || awaited_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0 && awaited_outcomes.size() == 0) begin
         $display("PASS hashed_id_set_duplicate_check");
      end else begin
         $display("FAIL hashed_id_set_duplicate_check");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legitimate run.
   initial begin
      #100_000_000;
      $display("FAIL hashed_id_set_duplicate_check");
      $finish;
   end

endmodule
